### rtl/core/stx_length_etx_deframer_defines.svh
// ----------------------------------------------------------------------------
// STX / length / ETX deframer assertion macros
// Concurrent assertion helpers shared by the deframer RTL.
// ----------------------------------------------------------------------------
`ifndef STX_LENGTH_ETX_DEFRAMER_DEFINES_SVH
`define STX_LENGTH_ETX_DEFRAMER_DEFINES_SVH

`ifndef SYNTHESIS

// The condition must never hold while out of reset.
`define SLED_ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("deframer assertion failed");

// The antecedent implies the consequent in the next cycle.
`define SLED_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("deframer assertion failed");

`else

`define SLED_ASSERT_NEVER(lbl, cond)
`define SLED_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

### rtl/core/sled_pkg.sv
// ----------------------------------------------------------------------------
// Deframer package
// Types and constants shared by the STX / length / ETX deframer modules.
// ----------------------------------------------------------------------------
`default_nettype none

package sled_pkg;

  localparam logic [7:0] STX_BYTE = 8'h02;
  localparam logic [7:0] ETX_BYTE = 8'h03;
  localparam logic [7:0] MIN_BODY_LEN_RST = 8'd4;
  localparam int unsigned LEN_W = 24;

  typedef enum logic [2:0] {
    PH_STX     = 3'd0,
    PH_LEN_HI  = 3'd1,
    PH_LEN_MID = 3'd2,
    PH_LEN_LO  = 3'd3,
    PH_BODY    = 3'd4,
    PH_ETX     = 3'd5,
    PH_HALT    = 3'd6
  } phase_t;

  typedef enum logic [1:0] {
    KIND_BODY = 2'd0,
    KIND_END  = 2'd1,
    KIND_ERR  = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ERR_NO_STX = 2'd0,
    ERR_SHORT  = 2'd1,
    ERR_NO_ETX = 2'd2
  } err_t;

  typedef struct packed {
    kind_t             kind;
    logic [7:0]        body_byte;
    logic [LEN_W-1:0]  frame_length;
    err_t              error_code;
  } result_t;

endpackage

`default_nettype wire

### rtl/core/sled_in_reg.sv
// ----------------------------------------------------------------------------
// Deframer input register
// Captures one received byte and holds it until the frame logic takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module sled_in_reg (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_rx_byte,
  input  wire logic       take,
  output logic            held_vld,
  output logic [7:0]      held_byte
);

  logic       vld_r;
  logic       vld_nxt;
  logic [7:0] byte_r;

  assign in_stall = vld_r & ~take;
  assign vld_nxt  = in_stall ? vld_r : in_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      byte_r <= in_rx_byte;
    end
  end

  assign held_vld  = vld_r;
  assign held_byte = byte_r;

endmodule

`default_nettype wire

### rtl/core/sled_frame_fsm.sv
// ----------------------------------------------------------------------------
// Deframer frame state machine
// Tracks the frame phase and length counters and forms at most one result per byte.
// ----------------------------------------------------------------------------
`default_nettype none

`include "stx_length_etx_deframer_defines.svh"

module sled_frame_fsm (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             cfg_wr_en,
  input  wire logic [7:0]       cfg_wr_data,
  input  wire logic             take,
  input  wire logic [7:0]       rx_byte,
  output logic                  has_result,
  output sled_pkg::result_t     result
);

  sled_pkg::phase_t              phase_r;
  sled_pkg::phase_t              phase_nxt;
  logic [sled_pkg::LEN_W-1:0]    len_r;
  logic [sled_pkg::LEN_W-1:0]    len_nxt;
  logic [sled_pkg::LEN_W-1:0]    rem_r;
  logic [sled_pkg::LEN_W-1:0]    rem_nxt;
  logic [sled_pkg::LEN_W-1:0]    len_shift;
  logic [sled_pkg::LEN_W-1:0]    rem_dec;
  logic [7:0]                    min_r;
  logic                          too_short;

  assign len_shift = {len_r[sled_pkg::LEN_W-9:0], rx_byte};
  assign rem_dec   = rem_r - {{(sled_pkg::LEN_W-1){1'b0}}, 1'b1};
  assign too_short = len_shift < {{(sled_pkg::LEN_W-8){1'b0}}, min_r};

  always_comb begin
    phase_nxt = phase_r;
    len_nxt   = len_r;
    rem_nxt   = rem_r;
    if (take) begin
      case (phase_r)
        sled_pkg::PH_STX: begin
          if (rx_byte != sled_pkg::STX_BYTE) begin
            phase_nxt = sled_pkg::PH_HALT;
          end else begin
            len_nxt   = '0;
            rem_nxt   = '0;
            phase_nxt = sled_pkg::PH_LEN_HI;
          end
        end
        sled_pkg::PH_LEN_HI: begin
          len_nxt   = len_shift;
          phase_nxt = sled_pkg::PH_LEN_MID;
        end
        sled_pkg::PH_LEN_MID: begin
          len_nxt   = len_shift;
          phase_nxt = sled_pkg::PH_LEN_LO;
        end
        sled_pkg::PH_LEN_LO: begin
          len_nxt = len_shift;
          if (too_short) begin
            phase_nxt = sled_pkg::PH_HALT;
          end else begin
            rem_nxt   = len_shift;
            phase_nxt = (len_shift == '0) ? sled_pkg::PH_ETX : sled_pkg::PH_BODY;
          end
        end
        sled_pkg::PH_BODY: begin
          rem_nxt = rem_dec;
          if (rem_dec == '0) begin
            phase_nxt = sled_pkg::PH_ETX;
          end
        end
        sled_pkg::PH_ETX: begin
          phase_nxt = (rx_byte != sled_pkg::ETX_BYTE) ? sled_pkg::PH_HALT
                                                      : sled_pkg::PH_STX;
        end
        default: begin
          phase_nxt = phase_r;
        end
      endcase
    end
  end

  always_comb begin
    has_result          = 1'b0;
    result.kind         = sled_pkg::KIND_BODY;
    result.body_byte    = '0;
    result.frame_length = '0;
    result.error_code   = sled_pkg::ERR_NO_STX;
    case (phase_r)
      sled_pkg::PH_STX: begin
        if (rx_byte != sled_pkg::STX_BYTE) begin
          has_result        = 1'b1;
          result.kind       = sled_pkg::KIND_ERR;
          result.error_code = sled_pkg::ERR_NO_STX;
        end
      end
      sled_pkg::PH_LEN_LO: begin
        if (too_short) begin
          has_result        = 1'b1;
          result.kind       = sled_pkg::KIND_ERR;
          result.error_code = sled_pkg::ERR_SHORT;
        end
      end
      sled_pkg::PH_BODY: begin
        has_result       = 1'b1;
        result.kind      = sled_pkg::KIND_BODY;
        result.body_byte = rx_byte;
      end
      sled_pkg::PH_ETX: begin
        has_result = 1'b1;
        if (rx_byte != sled_pkg::ETX_BYTE) begin
          result.kind       = sled_pkg::KIND_ERR;
          result.error_code = sled_pkg::ERR_NO_ETX;
        end else begin
          result.kind         = sled_pkg::KIND_END;
          result.frame_length = len_r;
        end
      end
      default: begin
        has_result = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= sled_pkg::PH_STX;
      len_r   <= '0;
      rem_r   <= '0;
      min_r   <= sled_pkg::MIN_BODY_LEN_RST;
    end else begin
      phase_r <= phase_nxt;
      len_r   <= len_nxt;
      rem_r   <= rem_nxt;
      if (cfg_wr_en) begin
        min_r <= cfg_wr_data;
      end
    end
  end

  // Once halted, only reset leaves the halted phase.
  `SLED_ASSERT_NEXT(a_halt_sticks, phase_r == sled_pkg::PH_HALT, phase_r == sled_pkg::PH_HALT)
  // Every reported error halts the block.
  `SLED_ASSERT_NEXT(a_err_halts, take && has_result && result.kind == sled_pkg::KIND_ERR, phase_r == sled_pkg::PH_HALT)
  // The body phase always has at least one byte left to come.
  `SLED_ASSERT_NEVER(a_body_nonzero, phase_r == sled_pkg::PH_BODY && rem_r == '0)
  // A good frame end returns the block to waiting for the next STX.
  `SLED_ASSERT_NEXT(a_end_restarts, take && has_result && result.kind == sled_pkg::KIND_END, phase_r == sled_pkg::PH_STX)

endmodule

`default_nettype wire

### rtl/core/sled_out_reg.sv
// ----------------------------------------------------------------------------
// Deframer result register
// Holds one result until the downstream side takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module sled_out_reg (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               take,
  input  wire logic               has_result,
  input  wire sled_pkg::result_t  result,
  output logic                    can_load,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [1:0]              out_result_kind,
  output logic [7:0]              out_body_byte,
  output logic [23:0]             out_frame_length,
  output logic [1:0]              out_error_code
);

  logic              vld_r;
  logic              vld_nxt;
  logic              load;
  sled_pkg::result_t res_r;

  assign can_load = ~vld_r | ~out_stall;
  assign load     = take & has_result;
  assign vld_nxt  = load | (vld_r & out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= result;
    end
  end

  assign out_valid        = vld_r;
  assign out_result_kind  = res_r.kind;
  assign out_body_byte    = res_r.body_byte;
  assign out_frame_length = res_r.frame_length;
  assign out_error_code   = res_r.error_code;

endmodule

`default_nettype wire

### rtl/core/stx_length_etx_deframer.sv
// ----------------------------------------------------------------------------
// STX / length / ETX deframer
// Splits a byte stream into frames, passes body bytes, flags ends and errors.
// ----------------------------------------------------------------------------
// The block takes one byte per clock cycle while no stall holds it and gives
// at most one result per byte. Each byte is captured in an input register, its
// result is formed by the frame state machine and held in a result register
// that drives out_valid. The state machine updates phase and counters for each
// byte it takes, which sets the rate of one byte per cycle while out_stall
// does not hold the result register. After any framing error the block reports
// it once and drops all bytes until reset; body bytes of a bad frame have
// already been passed on and must be dropped downstream.
`default_nettype none

module stx_length_etx_deframer (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_wr_en,
  input  wire logic [7:0]  cfg_wr_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_rx_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       out_result_kind,
  output logic [7:0]       out_body_byte,
  output logic [23:0]      out_frame_length,
  output logic [1:0]       out_error_code
);

  logic              held_vld;
  logic [7:0]        held_byte;
  logic              can_load;
  logic              take;
  logic              has_result;
  sled_pkg::result_t result;

  assign take = held_vld & can_load;

  sled_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_rx_byte (in_rx_byte),
    .take       (take),
    .held_vld   (held_vld),
    .held_byte  (held_byte)
  );

  sled_frame_fsm u_fsm (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .take        (take),
    .rx_byte     (held_byte),
    .has_result  (has_result),
    .result      (result)
  );

  sled_out_reg u_out_reg (
    .clk              (clk),
    .rst_n            (rst_n),
    .take             (take),
    .has_result       (has_result),
    .result           (result),
    .can_load         (can_load),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_result_kind  (out_result_kind),
    .out_body_byte    (out_body_byte),
    .out_frame_length (out_frame_length),
    .out_error_code   (out_error_code)
  );

endmodule

`default_nettype wire
